// ----- design/ate_pkg.sv -----
package ate_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SegW   = 7;
  localparam int unsigned SelW   = 4;
  localparam int unsigned WeekW  = 3;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned NumSets = 3;
  localparam int unsigned SetW   = 2;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;

  localparam logic [SelW-1:0]  SelLast = 4'd8;
  localparam logic [MinW-1:0]  MinLast = 6'd59;
  localparam logic [HourW-1:0] HourLast = 5'd23;

  typedef enum logic [OpW-1:0] {
    OP_RELEASED = 3'd0,
    OP_PLUS     = 3'd1,
    OP_MINUS    = 3'd2,
    OP_OK       = 3'd3,
    OP_NEXT     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FIELD_WEEK = 2'd0,
    FIELD_MIN  = 2'd1,
    FIELD_HOUR = 2'd2
  } field_e;

  // values of the displayed set after the update
  typedef struct packed {
    logic [WeekW-1:0] week;
    logic [MinW-1:0]  minute;
    logic [HourW-1:0] hour;
    logic [SelW-1:0]  selector;
    logic [NumSets-1:0] enable;
  } view_t;

  typedef struct packed {
    logic [SegW-1:0] hour_tens;
    logic [SegW-1:0] hour_ones;
    logic [SegW-1:0] min_tens;
    logic [SegW-1:0] min_ones;
    logic [SegW-1:0] set_week;
    logic [SegW-1:0] today;
  } seg_bus_t;

  function automatic logic [SegW-1:0] digit_seg(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SetW-1:0] set_of(input logic [SelW-1:0] sel);
    logic [SetW-1:0] s;
    if (sel >= 4'd6) begin
      s = 2'd2;
    end else if (sel >= 4'd3) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    return s;
  endfunction

  function automatic field_e field_of(input logic [SelW-1:0] sel);
    field_e f;
    case (sel)
      4'd0, 4'd3, 4'd6: f = FIELD_WEEK;
      4'd1, 4'd4, 4'd7: f = FIELD_MIN;
      default:          f = FIELD_HOUR;
    endcase
    return f;
  endfunction

endpackage

// ----- design/ate_edit.sv -----
module ate_edit import ate_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [OpW-1:0] op_i,
  output view_t          view_o
);

  logic [SelW-1:0]    selector_q, selector_d;
  logic               armed_q, armed_d;
  logic [WeekW-1:0]   week_q [NumSets];
  logic [WeekW-1:0]   week_d [NumSets];
  logic [MinW-1:0]    minute_q [NumSets];
  logic [MinW-1:0]    minute_d [NumSets];
  logic [HourW-1:0]   hour_q [NumSets];
  logic [HourW-1:0]   hour_d [NumSets];
  logic [NumSets-1:0] enable_q, enable_d;

  logic [SelW-1:0] sel_cur, sel_new;
  logic [SetW-1:0] set_cur, set_new;
  field_e          field_cur;
  logic            up;

  assign sel_cur   = (selector_q > SelLast) ? '0 : selector_q;
  assign set_cur   = set_of(sel_cur);
  assign field_cur = field_of(sel_cur);
  assign up        = (op_i == OP_PLUS);

  always_comb begin
    selector_d = selector_q;
    armed_d    = armed_q;
    week_d     = week_q;
    minute_d   = minute_q;
    hour_d     = hour_q;
    enable_d   = enable_q;
    if (fire_i) begin
      case (op_i)
        OP_PLUS, OP_MINUS: begin
          if (armed_q) begin
            armed_d = 1'b0;
            case (field_cur)
              FIELD_WEEK: begin
                week_d[set_cur] = up ? week_q[set_cur] + 3'd1 : week_q[set_cur] - 3'd1;
              end
              FIELD_MIN: begin
                if (up) begin
                  minute_d[set_cur] = (minute_q[set_cur] >= MinLast) ? '0
                                      : minute_q[set_cur] + 6'd1;
                end else begin
                  minute_d[set_cur] = (minute_q[set_cur] == '0) ? MinLast
                                      : minute_q[set_cur] - 6'd1;
                end
              end
              default: begin
                if (up) begin
                  hour_d[set_cur] = (hour_q[set_cur] >= HourLast) ? '0
                                    : hour_q[set_cur] + 5'd1;
                end else begin
                  hour_d[set_cur] = (hour_q[set_cur] == '0) ? HourLast
                                    : hour_q[set_cur] - 5'd1;
                end
              end
            endcase
          end
        end
        OP_OK: begin
          if (armed_q) begin
            armed_d           = 1'b0;
            enable_d[set_cur] = ~enable_q[set_cur];
          end
        end
        OP_NEXT: begin
          if (armed_q) begin
            armed_d    = 1'b0;
            selector_d = (sel_cur >= SelLast) ? '0 : sel_cur + 4'd1;
          end
        end
        OP_RELEASED: begin
          armed_d = 1'b1;
        end
        default: begin
          armed_d = armed_q;
        end
      endcase
    end
  end

  // display follows the selector after the update
  assign sel_new = (selector_d > SelLast) ? '0 : selector_d;
  assign set_new = set_of(sel_new);

  always_comb begin
    view_o.week     = week_d[set_new];
    view_o.minute   = minute_d[set_new];
    view_o.hour     = hour_d[set_new];
    view_o.selector = selector_d;
    view_o.enable   = enable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selector_q <= '0;
      armed_q    <= 1'b0;
      week_q     <= '{3'd0, 3'd1, 3'd1};
      minute_q   <= '{6'd1, 6'd0, 6'd0};
      hour_q     <= '{5'd0, 5'd0, 5'd0};
      enable_q   <= '0;
    end else begin
      selector_q <= selector_d;
      armed_q    <= armed_d;
      week_q     <= week_d;
      minute_q   <= minute_d;
      hour_q     <= hour_d;
      enable_q   <= enable_d;
    end
  end

endmodule

// ----- design/ate_disp.sv -----
module ate_disp import ate_pkg::*; (
  input  view_t             view_i,
  input  logic [DigitW-1:0] today_i,
  output seg_bus_t          seg_o
);

  logic [DigitW-1:0] min_tens, min_ones, hour_tens, hour_ones;
  logic [MinW-1:0]   min_base;
  logic [HourW-1:0]  hour_base;

  // tens digit by range compare, units by subtracting the tens weight
  always_comb begin
    if (view_i.minute >= 6'd50) begin
      min_tens = 4'd5;
    end else if (view_i.minute >= 6'd40) begin
      min_tens = 4'd4;
    end else if (view_i.minute >= 6'd30) begin
      min_tens = 4'd3;
    end else if (view_i.minute >= 6'd20) begin
      min_tens = 4'd2;
    end else if (view_i.minute >= 6'd10) begin
      min_tens = 4'd1;
    end else begin
      min_tens = 4'd0;
    end
    min_base = 6'(min_tens) * 6'd10;
    min_ones = 4'(view_i.minute - min_base);

    if (view_i.hour >= 5'd20) begin
      hour_tens = 4'd2;
    end else if (view_i.hour >= 5'd10) begin
      hour_tens = 4'd1;
    end else begin
      hour_tens = 4'd0;
    end
    hour_base = 5'(hour_tens) * 5'd10;
    hour_ones = 4'(view_i.hour - hour_base);
  end

  always_comb begin
    seg_o.today     = digit_seg(today_i);
    seg_o.set_week  = digit_seg({1'b0, view_i.week});
    seg_o.min_ones  = digit_seg(min_ones);
    seg_o.min_tens  = digit_seg(min_tens);
    seg_o.hour_ones = digit_seg(hour_ones);
    seg_o.hour_tens = digit_seg(hour_tens);
  end

endmodule

// ----- design/alarm_time_editor.sv -----
// channel   dir  fields (tdata, lowest bits first)
// s_axis    in   op[2:0], today_digit[6:3], zero pad [7]
// m_axis    out  seg_today, seg_set_week, seg_min_ones, seg_min_tens,
//                seg_hour_ones, seg_hour_tens (7 bits each), selected_item[45:42],
//                enable_main[46], enable_alarm_a[47], enable_alarm_b[48], zero pad
//
// one request per cycle while the result side is not stalled; a request is taken into the
// input register, then the edit and segment decode write its result into the result register
// reset sets the selector, arming and the three time sets to their start values
// and clears both valid flags
// a stalled result holds the output; one more request can wait in the input register
module alarm_time_editor import ate_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // op, today_digit
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // seg codes, selected_item, enables
);

  logic              in_valid_q, in_valid_d;
  logic [OpW-1:0]    op_q;
  logic [DigitW-1:0] today_q;
  logic              out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic              advance, fire;
  view_t             view;
  seg_bus_t          segs;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign fire          = in_valid_q && advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? in_valid_q : out_valid_q;

  ate_edit u_edit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op_q),
    .view_o (view)
  );

  ate_disp u_disp (
    .view_i  (view),
    .today_i (today_q),
    .seg_o   (segs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tdata[OpW-1:0];
      today_q <= s_axis_tdata[OpW +: DigitW];
    end
    if (fire) begin
      out_data_q <= {7'd0, view.enable, view.selector, segs};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[45:42] <= SelLast))
    else $error("selector out of range");

  a_view_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (view.minute <= MinLast) && (view.hour <= HourLast))
    else $error("time field out of range");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(op_q) && $stable(today_q)))
    else $error("waiting request lost");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("result not presented");
`endif

endmodule

// ----- sim/alarm_time_editor_tb.sv -----
`timescale 1ns / 100ps

module alarm_time_editor_tb;
  import ate_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned RandomKeys  = 1825;
  localparam int unsigned MaxWait     = 17;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LimitCycles = 500000;
  localparam int unsigned SelMax      = 8;
  localparam int unsigned WeekMod     = 8;
  localparam int unsigned MinMod      = 60;
  localparam int unsigned HourMod     = 24;

  // key codes the package leaves unnamed; the block treats them all as no-ops
  localparam logic [OpW-1:0] KEY_OTHER   = 3'd5;
  localparam logic [OpW-1:0] KEY_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] KEY_SPARE_7 = 3'd7;

  localparam logic [SegW-1:0] SEG_TABLE [0:9] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  typedef struct packed {
    logic [DigitW-1:0] today;
    logic [OpW-1:0]    key;
  } key_req_t;

  typedef struct packed {
    logic            en_b;
    logic            en_a;
    logic            en_main;
    logic [SelW-1:0] sel;
    logic [SegW-1:0] hour_tens;
    logic [SegW-1:0] hour_ones;
    logic [SegW-1:0] min_tens;
    logic [SegW-1:0] min_ones;
    logic [SegW-1:0] week;
    logic [SegW-1:0] today;
  } readout_t;

  localparam int unsigned ReadoutW = $bits(readout_t);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // op, today_digit
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // seg codes, selected_item, enables

  alarm_time_editor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // editor state as the predictor sees it
  int unsigned cur_sel;
  bit          armed;
  int unsigned week_q [3];
  int unsigned min_q [3];
  int unsigned hour_q [3];
  bit          en_q [3];

  key_req_t    key_queue [$];
  readout_t    readouts_due [$];

  bit          req_taken = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  int unsigned errors = 0;
  int unsigned keys_sent = 0;
  int unsigned readouts_checked = 0;
  int unsigned edits = 0;
  int unsigned toggles = 0;
  int unsigned sel_steps = 0;

  key_req_t    seen_req;
  readout_t    got_readout;
  readout_t    want_readout;

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic logic [SegW-1:0] seg_of(input int unsigned d);
    return (d < 10) ? SEG_TABLE[d] : '0;
  endfunction

  function automatic int unsigned wrap_step(input int unsigned v, input int unsigned modulus,
                                            input bit up);
    int unsigned x;
    x = v % modulus;
    if (up) begin
      x = (x + 1 == modulus) ? 0 : x + 1;
    end else begin
      x = (x == 0) ? modulus - 1 : x - 1;
    end
    return x;
  endfunction

  // applies one key sample to the editor state and returns the display after it
  function automatic readout_t apply_key(input logic [OpW-1:0] key,
                                         input logic [DigitW-1:0] today);
    int unsigned sel;
    int unsigned grp;
    int unsigned fld;
    int unsigned wk;
    int unsigned mn;
    int unsigned hr;
    bit          up;
    readout_t    r;
    sel = (cur_sel <= SelMax) ? cur_sel : 0;
    grp = sel / 3;
    fld = sel % 3;
    up  = (key == OP_PLUS);
    if (armed && (key == OP_PLUS || key == OP_MINUS)) begin
      case (fld)
        FIELD_WEEK: week_q[grp] = wrap_step(week_q[grp], WeekMod, up);
        FIELD_MIN:  min_q[grp]  = wrap_step(min_q[grp], MinMod, up);
        default:    hour_q[grp] = wrap_step(hour_q[grp], HourMod, up);
      endcase
      armed = 1'b0;
      edits++;
    end else if (armed && key == OP_OK) begin
      en_q[grp] = !en_q[grp];
      armed = 1'b0;
      toggles++;
    end else if (armed && key == OP_NEXT) begin
      cur_sel = (sel + 1 >= SelMax + 1) ? 0 : sel + 1;
      armed = 1'b0;
      sel_steps++;
    end else if (key == OP_RELEASED) begin
      armed = 1'b1;
    end

    sel = (cur_sel <= SelMax) ? cur_sel : 0;
    grp = sel / 3;
    wk  = week_q[grp] % WeekMod;
    mn  = (min_q[grp] % 64) % MinMod;
    hr  = (hour_q[grp] % 32) % HourMod;
    r.today     = seg_of(today);
    r.week      = seg_of(wk);
    r.min_ones  = seg_of(mn % 10);
    r.min_tens  = seg_of(mn / 10);
    r.hour_ones = seg_of(hr % 10);
    r.hour_tens = seg_of(hr / 10);
    r.sel       = cur_sel[SelW-1:0];
    r.en_main   = en_q[0];
    r.en_a      = en_q[1];
    r.en_b      = en_q[2];
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want_v,
                                      input longint unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  function automatic void push_req(input logic [OpW-1:0] key, input logic [DigitW-1:0] today);
    key_req_t q;
    q.key   = key;
    q.today = today;
    key_queue.push_back(q);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (key_queue.size() > 0) begin
          s_axis_tdata  <= {{(InDataW - $bits(key_req_t)){1'b0}}, key_queue.pop_front()};
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 99) == 0) begin
            send_steady = !send_steady;
          end
          send_gap = send_steady ? 0 : $urandom_range(0, MaxWait);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, one stall drawn per result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        if ($urandom_range(0, 99) == 0) begin
          recv_steady = !recv_steady;
        end
        stall_left = recv_steady ? 0 : $urandom_range(0, MaxWait);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // monitor: predicts on each accepted request and checks each accepted result
  always @(posedge clk_i) begin
    req_taken    <= s_axis_tvalid && s_axis_tready;
    result_taken <= m_axis_tvalid && m_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      seen_req = key_req_t'(s_axis_tdata[$bits(key_req_t)-1:0]);
      readouts_due.push_back(apply_key(seen_req.key, seen_req.today));
      keys_sent++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got_readout = readout_t'(m_axis_tdata[ReadoutW-1:0]);
      if (readouts_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual 0x%0h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_readout = readouts_due.pop_front();
        check_field("seg_today", want_readout.today, got_readout.today);
        check_field("seg_set_week", want_readout.week, got_readout.week);
        check_field("seg_min_ones", want_readout.min_ones, got_readout.min_ones);
        check_field("seg_min_tens", want_readout.min_tens, got_readout.min_tens);
        check_field("seg_hour_ones", want_readout.hour_ones, got_readout.hour_ones);
        check_field("seg_hour_tens", want_readout.hour_tens, got_readout.hour_tens);
        check_field("selected_item", want_readout.sel, got_readout.sel);
        check_field("enable_main", want_readout.en_main, got_readout.en_main);
        check_field("enable_alarm_a", want_readout.en_a, got_readout.en_a);
        check_field("enable_alarm_b", want_readout.en_b, got_readout.en_b);
        check_field("tdata padding", 0, m_axis_tdata[OutDataW-1:ReadoutW]);
        readouts_checked++;
      end
    end
  end

  initial begin : watchdog
    repeat (LimitCycles) @(posedge clk_i);
    $display("%0t: timeout with %0d results outstanding", $time, readouts_due.size());
    $display("alarm_time_editor test failed");
    $finish;
  end

  initial begin
    logic [OpW-1:0] key;
    int unsigned    pick;
    int unsigned    reps;
    int unsigned    wanted;

    cur_sel = 0;
    armed   = 1'b0;
    week_q  = '{0, 1, 1};
    min_q   = '{1, 0, 0};
    hour_q  = '{0, 0, 0};
    en_q    = '{0, 0, 0};

    // directed: disarmed presses, wraps at both ends, no-op keys, blank digits
    push_req(OP_PLUS, 4'd0);
    push_req(OP_RELEASED, 4'd9);
    push_req(OP_MINUS, 4'd15);
    push_req(OP_MINUS, 4'd10);
    push_req(OP_RELEASED, 4'd1);
    push_req(OP_PLUS, 4'd2);
    push_req(OP_RELEASED, 4'd3);
    push_req(OP_OK, 4'd4);
    push_req(OP_RELEASED, 4'd5);
    push_req(KEY_OTHER, 4'd6);
    push_req(KEY_SPARE_6, 4'd7);
    push_req(KEY_SPARE_7, 4'd8);
    push_req(OP_NEXT, 4'd11);
    push_req(OP_RELEASED, 4'd12);
    push_req(OP_MINUS, 4'd13);
    push_req(OP_RELEASED, 4'd14);
    push_req(OP_MINUS, 4'd0);
    push_req(OP_RELEASED, 4'd15);
    push_req(OP_PLUS, 4'd6);
    push_req(OP_RELEASED, 4'd7);
    push_req(OP_NEXT, 4'd8);
    push_req(OP_RELEASED, 4'd9);
    push_req(OP_MINUS, 4'd3);
    push_req(OP_RELEASED, 4'd4);
    push_req(OP_PLUS, 4'd5);

    // random: mostly press/release pairs, some long runs to reach the wraps, some noise
    wanted = key_queue.size() + RandomKeys;
    while (key_queue.size() < wanted) begin
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 99);
        key  = (pick < 35) ? OP_PLUS : (pick < 70) ? OP_MINUS : (pick < 90) ? OP_NEXT : OP_OK;
        if ((key == OP_PLUS || key == OP_MINUS) && $urandom_range(0, 5) == 0) begin
          reps = $urandom_range(20, 70);
        end else begin
          reps = $urandom_range(1, 4);
        end
        repeat (reps) begin
          // a held key is sampled several times but acts once
          repeat (($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1) begin
            push_req(key, DigitW'($urandom_range(0, 15)));
          end
          push_req(OP_RELEASED, DigitW'($urandom_range(0, 15)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          push_req(OpW'($urandom_range(0, 7)), DigitW'($urandom_range(0, 15)));
        end
      end
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (key_queue.size() != 0 || s_axis_tvalid || readouts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d key samples sent, %0d readouts compared", keys_sent, readouts_checked);
    $display("%0d field steps, %0d enable toggles, %0d selector moves",
             edits, toggles, sel_steps);
    if (errors == 0) begin
      $display("alarm_time_editor test passed");
    end else begin
      $display("alarm_time_editor test failed");
    end
    $finish;
  end

endmodule

// ----- alarm_time_editor.f -----
design/ate_pkg.sv
design/ate_edit.sv
design/ate_disp.sv
design/alarm_time_editor.sv
sim/alarm_time_editor_tb.sv
